// File: rtl/fixed_block_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The expression must hold at every clock edge.
`define FBPA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

// File: rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, request and status codes, and the controller interface types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int REQ_TYPE_W    = 2;
   localparam int OFFSET_W      = 24;
   localparam int STATUS_W      = 3;
   localparam int FREE_COUNT_W  = 9;
   localparam int BLOCK_SIZE_W  = 13;
   localparam int POOL_BLOCKS_W = 9;
   localparam int STRIDE_W      = 14;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 13;

   localparam logic [BLOCK_SIZE_W-1:0]  BLOCK_SIZE_RESET  = 13'd16;
   localparam logic [POOL_BLOCKS_W-1:0] POOL_BLOCKS_RESET = 9'd256;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ALLOC    = 2'd0,
      REQ_FREE     = 2'd1,
      REQ_CLEAR    = 2'd2,
      REQ_RESERVED = 2'd3
   } request_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED     = 3'd0,
      ST_EMPTY         = 3'd1,
      ST_FREED         = 3'd2,
      ST_OUT_OF_RANGE  = 3'd3,
      ST_MISALIGNED    = 3'd4,
      ST_NOT_ALLOCATED = 3'd5,
      ST_CLEARED       = 3'd6
   } status_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_SIZE  = 1'd0,
      CSR_POOL_BLOCKS = 1'd1
   } csr_reg_type;

   typedef enum logic [3:0] {
      S_CLR_LATCH,
      S_CLR_MUL,
      S_SWEEP,
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_MUL,
      S_FREE_CHK,
      S_FREE_DIV,
      S_FREE_WR,
      S_DONE
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            clr_latch;
      logic            mul_last;
      logic            sweep;
      logic            alloc_pop;
      logic            alloc_take;
      logic            alloc_mul;
      logic            capture_off;
      logic            div_start;
      logic            mark_read;
      logic            free_push;
      logic            rsp_load;
      status_code_type rsp_status;
   } fbpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic out_of_range;
      logic div_busy;
      logic rem_zero;
      logic mark_set;
      logic sweep_last;
      logic rsp_free;
   } fbpa_stat_type;

endpackage

// File: rtl/fbpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface fbpa_req_if import fbpa_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [OFFSET_W-1:0]   block_offset;

   modport source (output valid, output req_type, output block_offset, input ready);
   modport sink   (input valid, input req_type, input block_offset, output ready);

endinterface

// File: rtl/fbpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if import fbpa_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [OFFSET_W-1:0]     alloc_offset;
   logic [FREE_COUNT_W-1:0] free_count;

   modport source (output valid, output status, output alloc_offset, output free_count,
                   input ready);
   modport sink   (input valid, input status, input alloc_offset, input free_count,
                   output ready);

endinterface

// File: rtl/fbpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences clear, allocate and free requests over the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl import fbpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  request_code_type req_code,
   output logic             req_ready,
   input  fbpa_stat_type    stat,
   output fbpa_cmd_type     cmd
);

   fsm_state_type   state_ff, state_in;
   status_code_type status_ff, status_in;
   logic            clr_rsp_ff, clr_rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR_LATCH;
         status_ff  <= ST_CLEARED;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         status_ff  <= status_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      clr_rsp_in     = clr_rsp_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         S_CLR_LATCH: begin
            cmd.clr_latch = 1'b1;
            state_in      = S_CLR_MUL;
         end
         S_CLR_MUL: begin
            cmd.mul_last = 1'b1;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               if (clr_rsp_ff) begin
                  status_in  = ST_CLEARED;
                  clr_rsp_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_code)
                  REQ_ALLOC: begin
                     if (stat.count_zero) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        cmd.alloc_pop = 1'b1;
                        state_in      = S_ALLOC_RD;
                     end
                  end
                  REQ_FREE: begin
                     cmd.capture_off = 1'b1;
                     state_in        = S_FREE_CHK;
                  end
                  REQ_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR_LATCH;
                  end
                  REQ_RESERVED: begin
                     status_in = ST_OUT_OF_RANGE;
                     state_in  = S_DONE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ALLOC_RD: begin
            cmd.alloc_take = 1'b1;
            state_in       = S_ALLOC_MUL;
         end
         S_ALLOC_MUL: begin
            cmd.alloc_mul = 1'b1;
            status_in     = ST_ALLOCATED;
            state_in      = S_DONE;
         end
         S_FREE_CHK: begin
            if (stat.out_of_range) begin
               status_in = ST_OUT_OF_RANGE;
               state_in  = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_FREE_DIV;
            end
         end
         S_FREE_DIV: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  cmd.mark_read = 1'b1;
                  state_in      = S_FREE_WR;
               end else begin
                  status_in = ST_MISALIGNED;
                  state_in  = S_DONE;
               end
            end
         end
         S_FREE_WR: begin
            if (stat.mark_set) begin
               cmd.free_push = 1'b1;
               status_in     = ST_FREED;
            end else begin
               status_in = ST_NOT_ALLOCATED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR_LATCH;
         end
      endcase
   end

endmodule

// File: rtl/fbpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Free stack, allocated marks, stride multiplier, divider and response register.
// ----------------------------------------------------------------------------
module fbpa_datapath import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS  = 256,
   parameter int OFFSET_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fbpa_cmd_type             cmd,
   output fbpa_stat_type            stat,
   input  logic [OFFSET_W-1:0]      req_offset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [OFFSET_W-1:0]      rsp_alloc_offset,
   output logic [FREE_COUNT_W-1:0]  rsp_free_count
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = IDX_W + STRIDE_W;
   localparam int DCNT_W = $clog2(OFFSET_BITS + 1);
   localparam int CMP_W  = OFFSET_BITS + PROD_W;

   // Configuration registers and the values latched at each clear.
   logic [BLOCK_SIZE_W-1:0]  block_size_ff;
   logic [POOL_BLOCKS_W-1:0] pool_blocks_ff;
   logic [CNT_W-1:0]         n_ff;
   logic [STRIDE_W-1:0]      stride_ff;
   logic [PROD_W-1:0]        last_ff;
   logic [CNT_W-1:0]         pool_sat;

   // Stack pointer and the lowest pointer value since the last clear.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] low_ff;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] n_m1;

   logic [IDX_W-1:0] stack_mem [MAX_BLOCKS];
   logic [IDX_W-1:0] stack_q_ff;
   logic [IDX_W-1:0] pop_addr_ff;
   logic             direct_ff;
   logic [IDX_W-1:0] idx_ff;

   logic             mark_mem [MAX_BLOCKS];
   logic             mark_q_ff;
   logic             mark_we;
   logic [IDX_W-1:0] mark_waddr;
   logic             mark_wdata;
   logic [IDX_W-1:0] sweep_ff;

   logic [IDX_W-1:0]  mul_a;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;

   logic [OFFSET_BITS+OFFSET_W-1:0] off_ext;
   logic [OFFSET_BITS-1:0]          off_ff;

   logic [DCNT_W-1:0]      div_cnt_ff;
   logic [STRIDE_W-1:0]    rem_ff;
   logic [OFFSET_BITS-1:0] quo_ff;
   logic [STRIDE_W:0]      trial;
   logic [STRIDE_W:0]      trial_diff;
   logic                   trial_ge;
   logic [IDX_W-1:0]       free_idx;

   logic [CMP_W-1:0] cmp_off;
   logic [CMP_W-1:0] cmp_last;

   logic [OFFSET_BITS+PROD_W-1:0]   prod_ext;
   logic [OFFSET_BITS-1:0]          prod_mask;
   logic [OFFSET_W+OFFSET_BITS-1:0] prod_out_ext;
   logic [FREE_COUNT_W+CNT_W-1:0]   count_ext;

   logic rsp_valid_ff;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RESET;
         pool_blocks_ff <= POOL_BLOCKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_write_data[BLOCK_SIZE_W-1:0];
            CSR_POOL_BLOCKS: pool_blocks_ff <= csr_write_data[POOL_BLOCKS_W-1:0];
            default:         block_size_ff  <= block_size_ff;
         endcase
      end
   end

   always_comb begin
      if (32'(pool_blocks_ff) >= MAX_BLOCKS) begin
         pool_sat = CNT_W'(MAX_BLOCKS);
      end else begin
         pool_sat = CNT_W'(pool_blocks_ff);
      end
   end

   assign cnt_m1 = count_ff - 1'b1;
   assign n_m1   = n_ff - 1'b1;

   // Latched pool geometry and stack pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= '0;
      end else if (cmd.clr_latch) begin
         count_ff <= pool_sat;
         low_ff   <= pool_sat;
      end else if (cmd.alloc_pop) begin
         count_ff <= cnt_m1;
         if (cnt_m1 < low_ff) begin
            low_ff <= cnt_m1;
         end
      end else if (cmd.free_push) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_latch) begin
         n_ff      <= pool_sat;
         stride_ff <= STRIDE_W'(block_size_ff) + 1'b1;
      end
      if (cmd.mul_last) begin
         last_ff <= prod_in;
      end
   end

   // Free stack. Entries below the low mark still hold their own index from
   // the last clear, so they are never read from the array.
   always_ff @(posedge clock) begin
      if (cmd.free_push) begin
         stack_mem[count_ff[IDX_W-1:0]] <= free_idx;
      end
      if (cmd.alloc_pop) begin
         stack_q_ff  <= stack_mem[cnt_m1[IDX_W-1:0]];
         pop_addr_ff <= cnt_m1[IDX_W-1:0];
         direct_ff   <= (cnt_m1 < low_ff);
      end
      if (cmd.alloc_take) begin
         idx_ff <= direct_ff ? pop_addr_ff : stack_q_ff;
      end
   end

   // Allocated marks: one write port shared by the sweep, allocate and free.
   always_comb begin
      mark_we    = cmd.sweep | cmd.alloc_mul | cmd.free_push;
      mark_waddr = free_idx;
      mark_wdata = 1'b0;
      if (cmd.sweep) begin
         mark_waddr = sweep_ff;
      end else if (cmd.alloc_mul) begin
         mark_waddr = idx_ff;
         mark_wdata = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (cmd.mark_read) begin
         mark_q_ff <= mark_mem[free_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_latch) begin
         sweep_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   // Shared stride multiplier.
   assign mul_a   = cmd.mul_last ? n_m1[IDX_W-1:0] : idx_ff;
   assign prod_in = {{STRIDE_W{1'b0}}, mul_a} * {{IDX_W{1'b0}}, stride_ff};

   always_ff @(posedge clock) begin
      if (cmd.alloc_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Free offset, reduced to the internal offset width.
   assign off_ext = {{OFFSET_BITS{1'b0}}, req_offset};

   always_ff @(posedge clock) begin
      if (cmd.capture_off) begin
         off_ff <= off_ext[OFFSET_BITS-1:0];
      end
   end

   assign cmp_off  = {{PROD_W{1'b0}}, off_ff};
   assign cmp_last = {{OFFSET_BITS{1'b0}}, last_ff};

   // Restoring divider, one quotient bit per cycle.
   assign trial      = {rem_ff, quo_ff[OFFSET_BITS-1]};
   assign trial_ge   = (trial >= {1'b0, stride_ff});
   assign trial_diff = trial - {1'b0, stride_ff};
   assign free_idx   = quo_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DCNT_W'(OFFSET_BITS);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= off_ff;
      end else if (div_cnt_ff != '0) begin
         rem_ff <= trial_ge ? trial_diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
         quo_ff <= {quo_ff[OFFSET_BITS-2:0], trial_ge};
      end
   end

   // Response register.
   assign prod_ext     = {{OFFSET_BITS{1'b0}}, prod_ff};
   assign prod_mask    = prod_ext[OFFSET_BITS-1:0];
   assign prod_out_ext = {{OFFSET_W{1'b0}}, prod_mask};
   assign count_ext    = {{FREE_COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status     <= cmd.rsp_status;
         rsp_free_count <= count_ext[FREE_COUNT_W-1:0];
         if (cmd.rsp_status == ST_ALLOCATED) begin
            rsp_alloc_offset <= prod_out_ext[OFFSET_W-1:0];
         end else begin
            rsp_alloc_offset <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.count_zero   = (count_ff == '0);
      stat.out_of_range = (n_ff == '0) || (cmp_off > cmp_last);
      stat.div_busy     = (div_cnt_ff != '0);
      stat.rem_zero     = (rem_ff == '0);
      stat.mark_set     = mark_q_ff;
      stat.sweep_last   = (sweep_ff == IDX_W'(MAX_BLOCKS - 1));
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: rtl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal blocks of a pool as byte offsets.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   req_bus   in         valid/ready            req_type, block_offset
//   rsp_bus   out        valid/ready            status, alloc_offset, free_count
//   csr_*     in         write enable, no wait  csr_index, csr_write_data
//
// One request is in work at a time. A free runs a restoring divider that
// checks alignment one quotient bit per cycle, and a clear sweeps the marks
// one entry per cycle. After reset the clear sequence keeps req_bus not
// ready. A response waits in the output register while the next request is
// accepted; a stalled rsp_bus holds the last step.
//
// The free stack keeps a low-water pointer since the last clear: every entry
// below it still holds its own index, so the stack array needs no refill.
// Block size and pool size take effect at the next clear or reset.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS  = 256,
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   fbpa_req_if.sink               req_bus,
   fbpa_rsp_if.source             rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   fbpa_cmd_type  cmd;
   fbpa_stat_type stat;
   logic          req_ready;

   // The controller decides which step runs; it sees the datapath only
   // through the status flags.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_code  (request_code_type'(req_bus.req_type)),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the stack, the marks, the arithmetic and the
   // response register.
   fbpa_datapath #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_offset       (req_bus.block_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_alloc_offset (rsp_bus.alloc_offset),
      .rsp_free_count   (rsp_bus.free_count)
   );

   assign req_bus.ready = req_ready;

   // A response is only loaded when the output register can take it.
   `FBPA_ASSERT_SAME(a_load_when_free, cmd.rsp_load, stat.rsp_free, "response overwritten")

   // Only one client drives the mark write port at a time.
   `FBPA_ASSERT_ALWAYS(a_mark_port_single, $onehot0({cmd.sweep, cmd.alloc_mul, cmd.free_push}),
      "mark write port conflict")

   // A block goes back on the stack only if it was marked allocated.
   `FBPA_ASSERT_SAME(a_push_marked, cmd.free_push, stat.mark_set, "push of unmarked block")

   // One request at a time: the cycle after an accept the block is busy.
   `FBPA_ASSERT_NEXT(a_one_in_flight, req_bus.valid && req_bus.ready, !req_bus.ready,
      "request accepted while busy")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate, free, clear and reserved requests through the request
// channel, and reprograms block size and pool size between phases. An
// in-bench model of the LIFO free stack predicts every response word, and
// each response is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb_top;
   import fbpa_pkg::*;

   // Cycles with no accepted word on either channel before the run is
   // declared hung. The slowest legal stretch is a clear sweep overlapping the
   // long receiver hold-off and the longest sender gap; the limit is several
   // times that stretch.
   localparam int WATCHDOG_LIMIT = 4000;
   // Length of the one deliberate receiver hold-off, and the response
   // count at which it starts.
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT        = 80;
   localparam int PHASES         = 10;
   localparam int WORDS_PER_PHASE = 75;
   localparam int POOL_LIMIT     = 256;

   // One expected response word.
   typedef struct {
      status_code_type         status;
      logic [OFFSET_W-1:0]     alloc_offset;
      logic [FREE_COUNT_W-1:0] free_count;
   } pool_response_type;

   // Tracks the allocator state and the responses still owed by the block.
   class pool_tracker_type;
      logic [BLOCK_SIZE_W-1:0]  block_size_reg;
      logic [POOL_BLOCKS_W-1:0] pool_blocks_reg;
      logic [7:0]               stack_mem [POOL_LIMIT];
      bit                       taken [POOL_LIMIT];
      int unsigned              depth;
      int unsigned              live_blocks;
      int unsigned              live_stride;
      pool_response_type        awaited [$];
      int unsigned              mismatches;

      function new();
         block_size_reg  = BLOCK_SIZE_RESET;
         pool_blocks_reg = POOL_BLOCKS_RESET;
         mismatches      = 0;
         refill();
      endfunction

      // Clear and reset both latch the registers and restack every block.
      function void refill();
         live_blocks = (pool_blocks_reg > POOL_LIMIT) ? POOL_LIMIT : pool_blocks_reg;
         live_stride = block_size_reg + 1;
         for (int i = 0; i < POOL_LIMIT; i++) begin
            taken[i]     = 1'b0;
            stack_mem[i] = (i < live_blocks) ? 8'(i) : 8'd0;
         end
         depth = live_blocks;
      endfunction

      function void write_reg(csr_reg_type which, logic [CSR_DATA_W-1:0] value);
         if (which == CSR_BLOCK_SIZE) begin
            block_size_reg = value;
         end else begin
            pool_blocks_reg = value[POOL_BLOCKS_W-1:0];
         end
      endfunction

      // Applies one accepted request and queues the response it must give.
      function void note_request(request_code_type kind, logic [OFFSET_W-1:0] off);
         pool_response_type want;
         int unsigned       idx;
         longint unsigned   last_off;
         want.status       = ST_OUT_OF_RANGE;
         want.alloc_offset = '0;
         last_off = (live_blocks == 0) ? 0 : longint'(live_blocks - 1) * live_stride;
         case (kind)
            REQ_ALLOC: begin
               if (depth == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  depth = depth - 1;
                  idx = stack_mem[depth];
                  taken[idx] = 1'b1;
                  want.alloc_offset = OFFSET_W'(idx * live_stride);
                  want.status = ST_ALLOCATED;
               end
            end
            REQ_FREE: begin
               if (live_blocks == 0 || off > last_off) begin
                  want.status = ST_OUT_OF_RANGE;
               end else if (off % live_stride != 0) begin
                  want.status = ST_MISALIGNED;
               end else begin
                  idx = off / live_stride;
                  if (!taken[idx]) begin
                     want.status = ST_NOT_ALLOCATED;
                  end else begin
                     taken[idx] = 1'b0;
                     if (depth < POOL_LIMIT) begin
                        stack_mem[depth] = 8'(idx);
                        depth = depth + 1;
                     end
                     want.status = ST_FREED;
                  end
               end
            end
            REQ_CLEAR: begin
               refill();
               want.status = ST_CLEARED;
            end
            default: begin
               want.status = ST_OUT_OF_RANGE;
            end
         endcase
         want.free_count = FREE_COUNT_W'(depth);
         awaited.push_back(want);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [OFFSET_W-1:0] offset,
                                   logic [FREE_COUNT_W-1:0] count);
         pool_response_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: status %0d offset %0d free %0d",
                        status, offset, count);
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status || offset !== want.alloc_offset ||
             count !== want.free_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: expected status %0d offset %0d free %0d, ",
                         "got status %0d offset %0d free %0d"},
                        want.status, want.alloc_offset, want.free_count,
                        status, offset, count);
         end
      endfunction

      // Offset of a randomly chosen allocated block, if there is one.
      function bit pick_taken(output logic [OFFSET_W-1:0] off);
         int unsigned held [$];
         off = '0;
         for (int i = 0; i < POOL_LIMIT; i++)
            if (taken[i]) held.push_back(i);
         if (held.size() == 0) return 1'b0;
         off = OFFSET_W'(held[$urandom_range(0, held.size() - 1)] * live_stride);
         return 1'b1;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   fbpa_req_if req_bus ();
   fbpa_rsp_if rsp_bus ();

   pool_tracker_type sb;
   // When set, neither side inserts random idle cycles.
   bit          calm = 1'b0;
   int unsigned responses_seen = 0;
   int unsigned quiet_cycles = 0;

   fixed_block_pool_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none or a few cycles, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request word and returns at the edge where it is accepted.
   // The valid line is left high, so a back-to-back word never sees two
   // assignments in one time step; a gap lowers it first.
   task automatic send_word(input request_code_type kind, input logic [OFFSET_W-1:0] off);
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.block_offset <= off;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(kind, off);
   endtask

   // Random request shaped by the current pool: most frees target blocks
   // that really are allocated, the rest probe each rejection path.
   task automatic send_random_word();
      request_code_type    kind;
      logic [OFFSET_W-1:0] off;
      logic [OFFSET_W-1:0] hit;
      int unsigned         pick;
      int unsigned         n;
      int unsigned         s;
      kind = REQ_ALLOC;
      off  = OFFSET_W'($urandom);
      n    = sb.live_blocks;
      s    = sb.live_stride;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         kind = REQ_ALLOC;
      end else if (pick < 78) begin
         kind = REQ_FREE;
         if (sb.pick_taken(hit)) off = hit;
      end else if (pick < 84) begin
         // Aligned and in range, allocated or not.
         kind = REQ_FREE;
         if (n > 0) off = OFFSET_W'($urandom_range(0, n - 1) * s);
      end else if (pick < 88) begin
         kind = REQ_FREE;
         if (n > 0 && s > 1)
            off = OFFSET_W'($urandom_range(0, n - 1) * s + $urandom_range(1, s - 1));
      end else if (pick < 92) begin
         kind = REQ_FREE;
      end else if (pick < 94) begin
         // The last block's offset and the offset one above it.
         kind = REQ_FREE;
         if (n > 0) off = OFFSET_W'((n - 1) * s + $urandom_range(0, 1));
      end else if (pick < 97) begin
         kind = REQ_RESERVED;
      end else begin
         kind = REQ_CLEAR;
      end
      send_word(kind, off);
   endtask

   // Drops valid and waits for every owed response, so the block is idle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges; enable drops afterwards.
   task automatic program_pool(input logic [CSR_DATA_W-1:0] size_word,
                               input logic [CSR_DATA_W-1:0] count_word);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BLOCK_SIZE;
      csr_write_data   <= size_word;
      sb.write_reg(CSR_BLOCK_SIZE, size_word);
      @(posedge clock);
      csr_index        <= CSR_POOL_BLOCKS;
      csr_write_data   <= count_word;
      sb.write_reg(CSR_POOL_BLOCKS, count_word);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Response side: checks each accepted word and stalls at random. Once,
   // it holds ready low for a long stretch while the sender keeps offering,
   // so the output register fills and the request channel backs up.
   initial begin : response_side
      int unsigned hold_left;
      bit          pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_response(rsp_bus.status, rsp_bus.alloc_offset, rsp_bus.free_count);
            responses_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) rsp_bus.ready <= 1'b1;
         end else if (!pressure_done && responses_seen >= HOLD_AT) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            hold_left = idle_cycles();
            if (hold_left > 0) rsp_bus.ready <= 1'b0;
         end
      end
   end

   // Hang detector: counts edges at which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : request_side
      logic [CSR_DATA_W-1:0] size_word;
      logic [CSR_DATA_W-1:0] count_word;
      int unsigned           roll;
      sb = new();
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= REQ_ALLOC;
      req_bus.block_offset <= '0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_BLOCK_SIZE;
      csr_write_data       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset values: stride 17, 256 blocks. The block sweeps its marks
      // after reset; the sender simply waits for ready.
      send_word(REQ_FREE, 24'd0);              // nothing allocated yet
      send_word(REQ_ALLOC, 24'hFFFFFF);        // LIFO: the last block first
      send_word(REQ_ALLOC, 24'd0);
      send_word(REQ_FREE, 24'd4335);           // last block, 255 * 17
      send_word(REQ_FREE, 24'd4335);           // double free
      send_word(REQ_FREE, 24'd1);              // misaligned
      send_word(REQ_FREE, 24'd4336);           // one past the last block
      send_word(REQ_FREE, 24'hFFFFFF);
      send_word(REQ_RESERVED, 24'hFFFFFF);
      send_word(REQ_ALLOC, 24'd0);             // gets the freed block back
      send_word(REQ_CLEAR, 24'd0);

      // Zero block size and a single block. The first allocate still sees
      // the old geometry because new registers only apply at a clear.
      settle();
      program_pool(13'd0, 13'd1);
      send_word(REQ_ALLOC, 24'd0);
      send_word(REQ_CLEAR, 24'd0);
      send_word(REQ_ALLOC, 24'd0);
      send_word(REQ_ALLOC, 24'd0);             // empty pool
      send_word(REQ_FREE, 24'd1);
      send_word(REQ_FREE, 24'd0);
      send_word(REQ_FREE, 24'd0);

      // Largest block size with an empty pool.
      settle();
      program_pool(13'h1FFF, 13'd0);
      send_word(REQ_CLEAR, 24'd0);
      send_word(REQ_ALLOC, 24'd0);
      send_word(REQ_FREE, 24'd0);

      // Pool size above the maximum saturates to 256 blocks.
      settle();
      program_pool(13'h1FFF, 13'h1FFF);
      send_word(REQ_CLEAR, 24'd0);
      send_word(REQ_ALLOC, 24'd0);
      send_word(REQ_FREE, 24'd2088959);        // one below the last block
      send_word(REQ_FREE, 24'd2088960);        // 255 * 8192

      // Random phases, each with its own geometry. Small pools dominate so
      // the stack runs dry often; some phases run without any idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         roll = $urandom_range(0, 5);
         case (roll)
            0:       size_word = 13'd0;
            1:       size_word = 13'h1FFF;
            2:       size_word = 13'd4096;
            3:       size_word = 13'd9;
            4:       size_word = CSR_DATA_W'($urandom_range(9, 64));
            default: size_word = CSR_DATA_W'($urandom_range(0, 8191));
         endcase
         roll = $urandom_range(0, 99);
         count_word = CSR_DATA_W'($urandom_range(0, 15)) << POOL_BLOCKS_W;
         if (roll < 50)      count_word[8:0] = 9'($urandom_range(1, 12));
         else if (roll < 70) count_word[8:0] = 9'($urandom_range(13, 255));
         else if (roll < 80) count_word[8:0] = 9'd256;
         else if (roll < 85) count_word[8:0] = 9'd0;
         else                count_word[8:0] = 9'($urandom_range(257, 511));
         program_pool(size_word, count_word);
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) send_word(REQ_CLEAR, OFFSET_W'($urandom));
         repeat (WORDS_PER_PHASE) send_random_word();
      end

      // Drain, then give any stray response time to show up.
      calm = 1'b0;
      settle();
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
